FILE: hdl/vlan_pkg.sv
package vlan_pkg;

    // frame length limits
    localparam logic [10:0] MAX_UNTAGGED = 11'd1518;
    localparam logic [10:0] MAX_TAGGED   = MAX_UNTAGGED + 11'd4;
    localparam logic [10:0] MIN_TX_LEN   = 11'd14;
    localparam logic [10:0] MIN_RX_LEN   = 11'd18;
    localparam logic [10:0] POS_MAX      = 11'd2047;

    // byte positions of interest
    localparam logic [10:0] POS_TAG_AT   = 11'd11;
    localparam logic [10:0] POS_TYPE_HI  = 11'd12;
    localparam logic [10:0] POS_TCI_HI   = 11'd14;
    localparam logic [10:0] POS_TCI_LO   = 11'd15;

    // tag protocol identifier bytes
    localparam logic [7:0] TPID_HI = 8'h81;
    localparam logic [7:0] TPID_LO = 8'h00;

    // configuration register indexes
    localparam logic [1:0] REG_TX_VLAN_ID   = 2'd0;
    localparam logic [1:0] REG_TX_PRIORITY  = 2'd1;
    localparam logic [1:0] REG_STRIP_ENABLE = 2'd2;

    // result queue sizing
    localparam int MAX_BURST   = 5;
    localparam int QUEUE_DEPTH = 6;

    typedef enum logic [4:0] {
        MODE_PASS      = 5'b00001,
        MODE_TX_INSERT = 5'b00010,
        MODE_TX_REJECT = 5'b00100,
        MODE_RX_CHECK  = 5'b01000,
        MODE_RX_STRIP  = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        rejected;
        logic        tag_found;
        logic [11:0] vlan_id;
        logic [2:0]  prio;
    } result_t;

endpackage

FILE: hdl/vlan_tag_insert_strip.sv
// IEEE 802.1Q tag insert / strip, one frame byte per transfer. A transmit frame
// (op 0) gets 0x8100 and the configured TCI inserted after byte 11; a transmit
// frame shorter than 14 or longer than 1518 bytes gives only one result, on its
// last byte, with rejected set. A receive frame (op 1) of 18 to 1522 bytes with
// ethertype 0x8100 has bytes 12..15 removed while strip_enable is set, and its
// last result carries tag_found, seen_vlan_id and seen_priority. Direction,
// length and configuration are sampled on the byte with first_byte set. Each
// byte's results enter the result queue, whose slot 0 is the output register;
// the output gives one result per cycle while out_stall is low, and an inserted
// transmit frame gives four results more than its byte count. The input takes a
// byte every cycle while at most one result waits in the six-entry queue, and
// stalls while the four inserted tag bytes (or held receive bytes) drain.
module vlan_tag_insert_strip (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [10:0] frame_length,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        rejected,
    output logic        tag_found,
    output logic [11:0] seen_vlan_id,
    output logic [2:0]  seen_priority
);

    // configuration registers
    logic [11:0] tx_vlan_id_reg;
    logic [2:0]  tx_priority_reg;
    logic        strip_enable_reg;

    // frame state
    logic [10:0]     pos_reg, pos_next;
    vlan_pkg::mode_t mode_reg, mode_next;
    logic [7:0]      held_reg, held_next;
    logic [15:0]     tci_reg, tci_next;
    logic            seen_reg, seen_next;

    // result queue, slot 0 is the output register
    vlan_pkg::result_t q_reg [vlan_pkg::QUEUE_DEPTH];
    vlan_pkg::result_t q_next [vlan_pkg::QUEUE_DEPTH];
    logic [2:0]        count_reg, count_next;

    // results of the byte being accepted
    vlan_pkg::result_t burst [vlan_pkg::MAX_BURST];
    logic [2:0]        burst_len;

    logic in_xfer;
    logic out_xfer;

    function automatic vlan_pkg::result_t make_result(input logic [7:0] b, input logic l);
        vlan_pkg::result_t r;
        r = '0;
        r.data = b;
        r.last = l;
        return r;
    endfunction

    assign in_stall  = (count_reg > 3'd1);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = (count_reg != 3'd0);
    assign out_xfer  = out_valid && !out_stall;

    assign out_byte      = q_reg[0].data;
    assign out_last      = q_reg[0].last;
    assign rejected      = q_reg[0].rejected;
    assign tag_found     = q_reg[0].tag_found;
    assign seen_vlan_id  = q_reg[0].vlan_id;
    assign seen_priority = q_reg[0].prio;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_vlan_id_reg   <= '0;
            tx_priority_reg  <= '0;
            strip_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                vlan_pkg::REG_TX_VLAN_ID:   tx_vlan_id_reg   <= cfg_data;
                vlan_pkg::REG_TX_PRIORITY:  tx_priority_reg  <= cfg_data[2:0];
                vlan_pkg::REG_STRIP_ENABLE: strip_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // per-byte decision: results and next frame state
    always_comb
    begin
        logic [10:0]     pos;
        vlan_pkg::mode_t mode;
        logic [7:0]      held;
        logic [15:0]     tci;
        logic            seen;

        // frame start resamples direction, length and configuration
        if (first_byte)
        begin
            pos  = '0;
            held = '0;
            seen = 1'b0;
            if (!op)
            begin
                tci  = {tx_priority_reg, 1'b0, tx_vlan_id_reg};
                mode = (frame_length < vlan_pkg::MIN_TX_LEN ||
                        frame_length > vlan_pkg::MAX_UNTAGGED)
                       ? vlan_pkg::MODE_TX_REJECT : vlan_pkg::MODE_TX_INSERT;
            end
            else
            begin
                tci  = '0;
                mode = (strip_enable_reg && frame_length >= vlan_pkg::MIN_RX_LEN &&
                        frame_length <= vlan_pkg::MAX_TAGGED)
                       ? vlan_pkg::MODE_RX_CHECK : vlan_pkg::MODE_PASS;
            end
        end
        else
        begin
            pos  = pos_reg;
            mode = mode_reg;
            held = held_reg;
            tci  = tci_reg;
            seen = seen_reg;
        end

        for (int i = 0; i < vlan_pkg::MAX_BURST; i++)
        begin
            burst[i] = '0;
        end
        burst_len = 3'd0;
        mode_next = mode;
        held_next = held;
        tci_next  = tci;
        seen_next = seen;

        unique case (mode)
            vlan_pkg::MODE_TX_INSERT:
            begin
                if (pos < vlan_pkg::POS_TAG_AT)
                begin
                    burst[0]  = make_result(data_byte, last_byte);
                    burst_len = 3'd1;
                end
                else
                begin
                    burst[0]  = make_result(data_byte, 1'b0);
                    burst[1]  = make_result(vlan_pkg::TPID_HI, 1'b0);
                    burst[2]  = make_result(vlan_pkg::TPID_LO, 1'b0);
                    burst[3]  = make_result(tci[15:8], 1'b0);
                    burst[4]  = make_result(tci[7:0], last_byte);
                    burst_len = 3'd5;
                    mode_next = vlan_pkg::MODE_PASS;
                end
            end
            vlan_pkg::MODE_TX_REJECT:
            begin
                if (last_byte)
                begin
                    burst[0]          = make_result(8'd0, 1'b1);
                    burst[0].rejected = 1'b1;
                    burst_len         = 3'd1;
                end
            end
            vlan_pkg::MODE_RX_CHECK:
            begin
                if (pos < vlan_pkg::POS_TYPE_HI)
                begin
                    burst[0]  = make_result(data_byte, last_byte);
                    burst_len = 3'd1;
                end
                else if (pos == vlan_pkg::POS_TYPE_HI)
                begin
                    if (last_byte)
                    begin
                        burst[0]  = make_result(data_byte, 1'b1);
                        burst_len = 3'd1;
                    end
                    else
                    begin
                        held_next = data_byte;
                    end
                end
                else if (!last_byte && held == vlan_pkg::TPID_HI &&
                         data_byte == vlan_pkg::TPID_LO)
                begin
                    mode_next = vlan_pkg::MODE_RX_STRIP;
                end
                else
                begin
                    burst[0]  = make_result(held, 1'b0);
                    burst[1]  = make_result(data_byte, last_byte);
                    burst_len = 3'd2;
                    mode_next = vlan_pkg::MODE_PASS;
                end
            end
            vlan_pkg::MODE_RX_STRIP:
            begin
                if (pos == vlan_pkg::POS_TCI_HI)
                begin
                    tci_next = {data_byte, 8'd0};
                    if (last_byte)
                    begin
                        burst[0]  = make_result(vlan_pkg::TPID_HI, 1'b0);
                        burst[1]  = make_result(vlan_pkg::TPID_LO, 1'b0);
                        burst[2]  = make_result(data_byte, 1'b1);
                        burst_len = 3'd3;
                    end
                end
                else if (pos == vlan_pkg::POS_TCI_LO)
                begin
                    tci_next = {tci[15:8], data_byte};
                    if (last_byte)
                    begin
                        burst[0]  = make_result(vlan_pkg::TPID_HI, 1'b0);
                        burst[1]  = make_result(vlan_pkg::TPID_LO, 1'b0);
                        burst[2]  = make_result(tci[15:8], 1'b0);
                        burst[3]  = make_result(data_byte, 1'b1);
                        burst_len = 3'd4;
                    end
                    else
                    begin
                        seen_next = 1'b1;
                    end
                end
                else if (last_byte && seen)
                begin
                    burst[0]           = make_result(data_byte, 1'b1);
                    burst[0].tag_found = 1'b1;
                    burst[0].vlan_id   = tci[11:0];
                    burst[0].prio      = tci[15:13];
                    burst_len          = 3'd1;
                end
                else
                begin
                    burst[0]  = make_result(data_byte, last_byte);
                    burst_len = 3'd1;
                end
            end
            default:
            begin
                burst[0]  = make_result(data_byte, last_byte);
                burst_len = 3'd1;
            end
        endcase

        // frame end returns to pass through
        if (last_byte)
        begin
            mode_next = vlan_pkg::MODE_PASS;
            seen_next = 1'b0;
            held_next = '0;
        end
        pos_next = (pos < vlan_pkg::POS_MAX) ? pos + 11'd1 : pos;
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            mode_reg <= vlan_pkg::MODE_PASS;
            held_reg <= '0;
            tci_reg  <= '0;
            seen_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            pos_reg  <= pos_next;
            mode_reg <= mode_next;
            held_reg <= held_next;
            tci_reg  <= tci_next;
            seen_reg <= seen_next;
        end
    end

    // queue update: pop the head, append this byte's results behind the rest
    always_comb
    begin
        logic [2:0] base;
        logic [2:0] add;
        logic [3:0] limit;
        logic [2:0] k;

        base  = count_reg - {2'd0, out_xfer};
        add   = in_xfer ? burst_len : 3'd0;
        limit = {1'b0, base} + {1'b0, add};
        for (int i = 0; i < vlan_pkg::QUEUE_DEPTH; i++)
        begin
            if (out_xfer && i < vlan_pkg::QUEUE_DEPTH - 1)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            k = 3'(i) - base;
            if (3'(i) >= base && 4'(i) < limit)
            begin
                q_next[i] = burst[k];
            end
        end
        count_next = base + add;
    end

    // queue occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < vlan_pkg::QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

FILE: hdl/vlan_chk.sv
module vlan_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        out_last,
    input logic        rejected,
    input logic        tag_found,
    input logic [11:0] seen_vlan_id,
    input logic [2:0]  seen_priority
);

    // a rejected frame shows one blank closing result
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> out_last && out_byte == 8'd0 && !tag_found)
        else $error("rejected result not a blank last result");

    // tag report only on the closing result
    a_tag_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tag_found |-> out_last && !rejected)
        else $error("tag_found outside the last result");

    // tag fields stay zero without a stripped tag
    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tag_found |-> seen_vlan_id == 12'd0 && seen_priority == 3'd0)
        else $error("tag fields set without tag_found");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled result changed");

endmodule

bind vlan_tag_insert_strip vlan_chk u_vlan_chk (.*);

FILE: tb/sv/vlan_tb_pkg.sv
`timescale 1ns / 1ps

package vlan_tb_pkg;

    import vlan_pkg::*;

    // frame direction
    localparam logic OP_TX = 1'b0;
    localparam logic OP_RX = 1'b1;

    // one byte offered on the input channel
    typedef struct packed {
        logic        op;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [10:0] len;
    } stim_byte_t;

    // one result on the output channel, in port order
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        rej;
        logic        found;
        logic [11:0] vid;
        logic [2:0]  prio;
    } out_beat_t;

    class vlan_frame_tracker;

        out_beat_t   expected_beats[$];
        int          errors;

        // shadow of the configuration registers
        logic [11:0] vid_reg;
        logic [2:0]  prio_reg;
        logic        strip_reg;

        // frame walk state
        int          byte_pos;
        mode_t       mode;
        logic [7:0]  held;
        logic [15:0] tci;
        logic        tag_seen;

        function new();
            errors    = 0;
            vid_reg   = '0;
            prio_reg  = '0;
            strip_reg = 1'b0;
            byte_pos  = 0;
            mode      = MODE_PASS;
            held      = '0;
            tci       = '0;
            tag_seen  = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] value);
            case (idx)
                REG_TX_VLAN_ID:   vid_reg = value;
                REG_TX_PRIORITY:  prio_reg = value[2:0];
                REG_STRIP_ENABLE: strip_reg = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void emit(logic [7:0] b, logic last, logic rej, logic found,
                           logic [11:0] vid, logic [2:0] prio);
            out_beat_t beat;
            beat.data  = b;
            beat.last  = last;
            beat.rej   = rej;
            beat.found = found;
            beat.vid   = vid;
            beat.prio  = prio;
            expected_beats.insert(expected_beats.size(), beat);
        endfunction

        // work out the results caused by one accepted input transfer
        function void note_input_byte(stim_byte_t s);
            int p;
            if (s.first) begin
                p        = 0;
                held     = '0;
                tag_seen = 1'b0;
                if (s.op == OP_TX) begin
                    tci = {prio_reg, 1'b0, vid_reg};
                    if (s.len < MIN_TX_LEN || s.len > MAX_UNTAGGED)
                        mode = MODE_TX_REJECT;
                    else
                        mode = MODE_TX_INSERT;
                end
                else begin
                    tci = '0;
                    if (strip_reg && s.len >= MIN_RX_LEN && s.len <= MAX_TAGGED)
                        mode = MODE_RX_CHECK;
                    else
                        mode = MODE_PASS;
                end
            end
            else begin
                p = byte_pos;
            end

            case (mode)
                MODE_TX_INSERT:
                begin
                    if (p < POS_TAG_AT) begin
                        emit(s.data, s.last, 0, 0, 0, 0);
                    end
                    else begin
                        // byte 11 then the four tag bytes
                        emit(s.data, 0, 0, 0, 0, 0);
                        emit(TPID_HI, 0, 0, 0, 0, 0);
                        emit(TPID_LO, 0, 0, 0, 0, 0);
                        emit(tci[15:8], 0, 0, 0, 0, 0);
                        emit(tci[7:0], s.last, 0, 0, 0, 0);
                        mode = MODE_PASS;
                    end
                end
                MODE_TX_REJECT:
                begin
                    if (s.last)
                        emit(8'h00, 1, 1, 0, 0, 0);
                end
                MODE_RX_CHECK:
                begin
                    if (p < POS_TYPE_HI) begin
                        emit(s.data, s.last, 0, 0, 0, 0);
                    end
                    else if (p == POS_TYPE_HI) begin
                        if (s.last)
                            emit(s.data, 1, 0, 0, 0, 0);
                        else
                            held = s.data;
                    end
                    else if (!s.last && held == TPID_HI && s.data == TPID_LO) begin
                        mode = MODE_RX_STRIP;
                    end
                    else begin
                        emit(held, 0, 0, 0, 0, 0);
                        emit(s.data, s.last, 0, 0, 0, 0);
                        mode = MODE_PASS;
                    end
                end
                MODE_RX_STRIP:
                begin
                    if (p == POS_TCI_HI) begin
                        tci = {s.data, 8'h00};
                        // frame cut inside the tag: give back what was held
                        if (s.last) begin
                            emit(TPID_HI, 0, 0, 0, 0, 0);
                            emit(TPID_LO, 0, 0, 0, 0, 0);
                            emit(s.data, 1, 0, 0, 0, 0);
                        end
                    end
                    else if (p == POS_TCI_LO) begin
                        tci[7:0] = s.data;
                        if (s.last) begin
                            emit(TPID_HI, 0, 0, 0, 0, 0);
                            emit(TPID_LO, 0, 0, 0, 0, 0);
                            emit(tci[15:8], 0, 0, 0, 0, 0);
                            emit(s.data, 1, 0, 0, 0, 0);
                        end
                        else begin
                            tag_seen = 1'b1;
                        end
                    end
                    else if (s.last && tag_seen) begin
                        emit(s.data, 1, 0, 1, tci[11:0], tci[15:13]);
                    end
                    else begin
                        emit(s.data, s.last, 0, 0, 0, 0);
                    end
                end
                default:
                begin
                    emit(s.data, s.last, 0, 0, 0, 0);
                end
            endcase

            if (s.last) begin
                mode     = MODE_PASS;
                tag_seen = 1'b0;
                held     = '0;
            end
            byte_pos = (p < POS_MAX) ? p + 1 : POS_MAX;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // compare one output transfer with the oldest expectation
        function void check_output_byte(out_beat_t got);
            out_beat_t want;
            if (expected_beats.size() == 0) begin
                $error("out_byte: expected no transfer, got %0h", got.data);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("out_byte", want.data, got.data);
            compare_field("out_last", want.last, got.last);
            compare_field("rejected", want.rej, got.rej);
            compare_field("tag_found", want.found, got.found);
            compare_field("seen_vlan_id", want.vid, got.vid);
            compare_field("seen_priority", want.prio, got.prio);
        endfunction

    endclass

endpackage

FILE: tb/sv/vlan_tag_insert_strip_tb.sv
`timescale 1ns / 1ps

module vlan_tag_insert_strip_tb;

    import vlan_pkg::*;
    import vlan_tb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic [10:0] frame_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        rejected;
    logic        tag_found;
    logic [11:0] seen_vlan_id;
    logic [2:0]  seen_priority;

    vlan_frame_tracker tracker = new();
    stim_byte_t        segment_bytes[$];
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                trunc_count = 0;
    logic              pressure_armed = 1'b0;
    logic              long_hold = 1'b0;
    int                boundary_lens[10] = '{0, 13, 14, 17, 18, 1518, 1519, 1522, 1523, 2047};

    vlan_tag_insert_strip dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .last_byte     (last_byte),
        .frame_length  (frame_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .rejected      (rejected),
        .tag_found     (tag_found),
        .seen_vlan_id  (seen_vlan_id),
        .seen_priority (seen_priority)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_output_byte({out_byte, out_last, rejected, tag_found,
                                       seen_vlan_id, seen_priority});
        out_stall <= long_hold || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // long receiver hold-off so the block fills and stalls its input
    initial
    begin
        wait (pressure_armed);
        repeat (6) @(posedge clk);
        long_hold <= 1'b1;
        repeat (150) @(posedge clk);
        long_hold <= 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void add_byte(logic o, logic [7:0] d, logic f, logic l,
                                     logic [10:0] len);
        stim_byte_t s;
        s.op    = o;
        s.data  = d;
        s.first = f;
        s.last  = l;
        s.len   = len;
        segment_bytes.insert(segment_bytes.size(), s);
    endfunction

    // one frame, optionally with an ethertype at bytes 12 and 13
    function automatic void add_frame(logic o, int count, logic [10:0] len,
                                      logic put_type, logic [15:0] etype, logic ends);
        logic [7:0]  d;
        logic        o_now;
        logic [10:0] len_now;
        for (int i = 0; i < count; i++) begin
            d = 8'($urandom_range(0, 255));
            if (put_type && i == 12)
                d = etype[15:8];
            if (put_type && i == 13)
                d = etype[7:0];
            o_now   = o;
            len_now = len;
            // direction and length after byte 0 must not matter
            if (i != 0 && $urandom_range(0, 7) == 0) begin
                o_now   = 1'($urandom_range(0, 1));
                len_now = 11'($urandom_range(0, 2047));
            end
            add_byte(o_now, d, i == 0, ends && i == count - 1, len_now);
        end
    endfunction

    function automatic void add_clean_frame();
        logic        o;
        int          n;
        logic [10:0] len;
        logic        with_tag;
        o = 1'($urandom_range(0, 1));
        if (o == OP_TX) begin
            n        = $urandom_range(14, 22);
            with_tag = ($urandom_range(0, 9) == 0);
        end
        else begin
            n        = $urandom_range(18, 26);
            with_tag = ($urandom_range(0, 3) != 0);
        end
        len = 11'(n);
        if ($urandom_range(0, 5) == 0)
            len = 11'(boundary_lens[$urandom_range(0, 9)]);
        add_frame(o, n, len, with_tag, {TPID_HI, TPID_LO}, 1'b1);
    endfunction

    // mostly good frames, frames cut around the tag, and some noise
    function automatic void add_random_traffic(int budget);
        int          roll;
        int          n;
        logic        o;
        logic [7:0]  hi;
        logic [15:0] etype;
        while (segment_bytes.size() < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                add_clean_frame();
            end
            else if (roll < 80) begin
                // last byte walks through positions 11 to 15
                n = 12 + (trunc_count % 5);
                trunc_count++;
                o = ($urandom_range(0, 9) < 7) ? OP_RX : OP_TX;
                add_frame(o, n, 11'($urandom_range(18, 64)), $urandom_range(0, 4) != 0,
                          {TPID_HI, TPID_LO}, 1'b1);
            end
            else begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        // stray bytes outside any frame start
                        n = $urandom_range(1, 3);
                        for (int i = 0; i < n; i++)
                            add_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                     1'b0, (i == n - 1) && $urandom_range(0, 1),
                                     11'($urandom_range(0, 2047)));
                    end
                    1:
                    begin
                        // frame abandoned by the next start
                        add_frame(1'($urandom_range(0, 1)), $urandom_range(1, 16),
                                  11'($urandom_range(0, 2047)), $urandom_range(0, 1),
                                  {TPID_HI, TPID_LO}, 1'b0);
                    end
                    default:
                    begin
                        // ethertype one byte off the tag id
                        if ($urandom_range(0, 1)) begin
                            etype = {TPID_HI, 8'($urandom_range(1, 255))};
                        end
                        else begin
                            hi = 8'($urandom_range(0, 254));
                            if (hi >= TPID_HI)
                                hi = hi + 8'd1;
                            etype = {hi, TPID_LO};
                        end
                        n = $urandom_range(18, 22);
                        add_frame(OP_RX, n, 11'(n), 1'b1, etype, 1'b1);
                    end
                endcase
            end
        end
        add_clean_frame();
    endfunction

    task automatic write_cfg(logic [1:0] idx, logic [11:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        tracker.set_reg(idx, value);
    endtask

    // register writes carry random bits above the register width
    task automatic load_config(logic [11:0] vid, logic [2:0] prio, logic strip);
        write_cfg(REG_TX_VLAN_ID, vid);
        write_cfg(REG_TX_PRIORITY, {9'($urandom_range(0, 511)), prio});
        write_cfg(REG_STRIP_ENABLE, {11'($urandom_range(0, 2047)), strip});
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // offer one byte and wait for its transfer
    task automatic send_byte(stim_byte_t s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= s.op;
        data_byte    <= s.data;
        first_byte   <= s.first;
        last_byte    <= s.last;
        frame_length <= s.len;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        tracker.note_input_byte(s);
    endtask

    task automatic send_all();
        foreach (segment_bytes[i])
            send_byte(segment_bytes[i]);
        in_valid <= 1'b0;
        segment_bytes.delete();
    endtask

    // all results in, then let any byte with no result settle
    task automatic wait_drained();
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic run_phase(logic [11:0] vid, logic [2:0] prio, logic strip,
                             int send_pct, int recv_pct, int budget);
        load_config(vid, prio, strip);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        add_random_traffic(budget);
        send_all();
        wait_drained();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames
        load_config(12'hFFF, 3'd7, 1'b1);
        send_idle_pct = 36;
        recv_idle_pct = 61;
        add_byte(OP_RX, 8'h00, 1'b0, 1'b0, 11'd0);
        add_byte(OP_TX, 8'hFF, 1'b0, 1'b1, 11'd2047);
        add_frame(OP_TX, 2, 11'd13, 1'b0, 16'h0000, 1'b1);
        add_frame(OP_TX, 1, 11'd1519, 1'b0, 16'h0000, 1'b1);
        add_frame(OP_TX, 1, 11'd0, 1'b0, 16'h0000, 1'b1);
        add_frame(OP_TX, 2, 11'd2047, 1'b0, 16'h0000, 1'b1);
        add_frame(OP_RX, 2, 11'd2047, 1'b0, 16'h0000, 1'b1);
        add_frame(OP_TX, 5, 11'd14, 1'b0, 16'h0000, 1'b1);
        add_frame(OP_TX, 3, 11'd1518, 1'b0, 16'h0000, 1'b0);
        add_frame(OP_RX, 3, 11'd1522, 1'b0, 16'h0000, 1'b0);
        add_frame(OP_RX, 3, 11'd18, 1'b0, 16'h0000, 1'b1);
        send_all();
        wait_drained();

        // random traffic: receiver idles more, then sender, then neither
        run_phase(12'h000, 3'd0, 1'b0, 36, 61, 20);
        run_phase(12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7)), 1'b1, 36, 61, 20);
        run_phase(12'hFFF, 3'd0, 1'b1, 61, 36, 20);
        run_phase(12'h000, 3'd7, 1'b0, 61, 36, 20);
        pressure_armed = 1'b1;
        run_phase(12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7)), 1'b1, 0, 0, 20);
        run_phase(12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7)), 1'b1, 0, 0, 20);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/vlan_pkg.sv
hdl/vlan_tag_insert_strip.sv
hdl/vlan_chk.sv
tb/sv/vlan_tb_pkg.sv
tb/sv/vlan_tag_insert_strip_tb.sv
